[rtl/core/svs_pkg.sv]
`default_nettype none

package svs_pkg;

    localparam int NUM_SECTIONS   = 16;
    localparam int SECTION_VOXELS = 4096;
    localparam int STORE_DEPTH    = NUM_SECTIONS * SECTION_VOXELS;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int SECT_CMP_W     = 5;

    localparam logic [3:0] SKY_RESET = 4'hF;

    typedef enum logic [2:0] {
        REQ_SET_BLOCK = 3'd0,
        REQ_GET_BLOCK = 3'd1,
        REQ_SET_BLK   = 3'd2,
        REQ_GET_BLK   = 3'd3,
        REQ_SET_SKY   = 3'd4,
        REQ_GET_SKY   = 3'd5
    } req_code_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS
    } seq_state_t;

    // one stored voxel
    typedef struct packed {
        logic [3:0] sky;
        logic [3:0] blk;
        logic [3:0] meta;
        logic [7:0] id;
    } word_t;

    localparam word_t WORD_RESET = '{sky: SKY_RESET, blk: 4'd0, meta: 4'd0, id: 8'd0};
    localparam int    WORD_W     = $bits(word_t);

    typedef struct packed {
        logic [2:0] req_type;
        logic [3:0] pos_x;
        logic [7:0] pos_y;
        logic [3:0] pos_z;
        logic [7:0] block_id;
        logic [3:0] block_meta;
        logic [3:0] light_level;
    } req_t;

    typedef struct packed {
        logic [7:0] id;
        logic [3:0] meta;
        logic [3:0] light;
    } res_t;

    typedef struct packed {
        logic accept;
        logic complete;
        logic clear_we;
    } seq_ctl_t;

    // section in the upper height bits, then layer, z, x
    function automatic logic [ADDR_W-1:0] voxel_addr(input logic [7:0] y,
                                                    input logic [3:0] z,
                                                    input logic [3:0] x);
        voxel_addr = ADDR_W'({y, z, x});
    endfunction

endpackage

`default_nettype wire

[rtl/core/svs_ram.sv]
`default_nettype none

module svs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/svs_seq.sv]
`default_nettype none

module svs_seq
    import svs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      seq_ctl_t          ctl,
    output      logic [ADDR_W-1:0] clear_addr
);

    seq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              clear_last;
    logic              out_free;

    assign clear_last = (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1));
    assign out_free   = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        ctl          = '0;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear_we = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                ctl.accept = in_valid;
            end
            ST_ACCESS:
            begin
                ctl.complete = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.complete)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign clear_addr = clr_cnt_reg;

endmodule

`default_nettype wire

[rtl/core/svs_rmw.sv]
`default_nettype none

module svs_rmw
    import svs_pkg::*;
(
    input  wire req_t  req,
    input  wire word_t rd_word,
    output      logic  hit,
    output      logic  wr_en,
    output      word_t wr_word,
    output      res_t  res
);

    always_comb
    begin
        hit = (req.req_type <= REQ_GET_SKY)
            && ({1'b0, req.pos_y[7:4]} < SECT_CMP_W'(NUM_SECTIONS));
    end

    // merge the request into the old word; reads leave it untouched
    always_comb
    begin
        wr_en   = 1'b0;
        wr_word = rd_word;
        res     = '0;
        if (hit)
        begin
            case (req.req_type)
                REQ_SET_BLOCK:
                begin
                    wr_en        = 1'b1;
                    wr_word.id   = req.block_id;
                    wr_word.meta = req.block_meta;
                end
                REQ_GET_BLOCK:
                begin
                    res.id   = rd_word.id;
                    res.meta = rd_word.meta;
                end
                REQ_SET_BLK:
                begin
                    wr_en       = 1'b1;
                    wr_word.blk = req.light_level;
                end
                REQ_GET_BLK:
                begin
                    res.light = rd_word.blk;
                end
                REQ_SET_SKY:
                begin
                    wr_en       = 1'b1;
                    wr_word.sky = req.light_level;
                end
                REQ_GET_SKY:
                begin
                    res.light = rd_word.sky;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/sectioned_voxel_store.sv]
// Channel  Handshake            Fields
// -------  -------------------  ---------------------------------------------------
// in       in_valid / in_ready  req_type pos_x pos_y pos_z block_id block_meta
//                               light_level
// out      out_valid/out_ready  read_id read_meta read_light section_mask
//
// Each transfer first reads the voxel word from the store (registered read), then
// merges and writes it back while loading the result. After reset a clearing
// pass writes every one of the STORE_DEPTH words; in_ready stays low until it ends.
// A new request is taken while a result still waits; the write-back step holds
// until the result register is free.
`default_nettype none

module sectioned_voxel_store
    import svs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire logic [2:0] req_type,
    input  wire logic [3:0] pos_x,
    input  wire logic [7:0] pos_y,
    input  wire logic [3:0] pos_z,
    input  wire logic [7:0] block_id,
    input  wire logic [3:0] block_meta,
    input  wire logic [3:0] light_level,
    output      logic       out_valid,
    input  wire logic       out_ready,
    output      logic [7:0] read_id,
    output      logic [3:0] read_meta,
    output      logic [3:0] read_light,
    output      logic [15:0] section_mask
);

    seq_ctl_t          ctl;
    logic [ADDR_W-1:0] clear_addr;

    req_t              req_reg;
    word_t             rd_word;
    word_t             wr_word;
    logic              hit;
    logic              wr_en;
    res_t              res;

    logic [15:0]       present_reg, present_next;
    res_t              res_reg;
    logic [15:0]       mask_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    word_t             ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    // sequencer: clearing pass, transfer acceptance, write-back timing
    svs_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ctl        (ctl),
        .clear_addr (clear_addr)
    );

    // hold the request across the read cycle
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            req_reg.req_type    <= req_type;
            req_reg.pos_x       <= pos_x;
            req_reg.pos_y       <= pos_y;
            req_reg.pos_z       <= pos_z;
            req_reg.block_id    <= block_id;
            req_reg.block_meta  <= block_meta;
            req_reg.light_level <= light_level;
        end
    end

    // the clearing pass owns the write port until it ends; afterwards only the
    // write-back step writes, so a read issued later always sees the new word
    assign ram_we    = ctl.clear_we || (ctl.complete && wr_en);
    assign ram_waddr = ctl.clear_we ? clear_addr
                                    : voxel_addr(req_reg.pos_y, req_reg.pos_z, req_reg.pos_x);
    assign ram_wdata = ctl.clear_we ? WORD_RESET : wr_word;

    svs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctl.accept),
        .raddr (voxel_addr(pos_y, pos_z, pos_x)),
        .rdata (ram_rdata)
    );

    assign rd_word = word_t'(ram_rdata);

    svs_rmw u_rmw (
        .req     (req_reg),
        .rd_word (rd_word),
        .hit     (hit),
        .wr_en   (wr_en),
        .wr_word (wr_word),
        .res     (res)
    );

    // mark the touched section; the result carries the mask after this request
    always_comb
    begin
        present_next = present_reg;
        if (hit)
        begin
            present_next = present_reg | (16'd1 << req_reg.pos_y[7:4]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
        end
        else if (ctl.complete)
        begin
            present_reg <= present_next;
        end
    end

    // result register: loaded at write-back, held until the out transfer
    always_ff @(posedge clk)
    begin
        if (ctl.complete)
        begin
            res_reg  <= res;
            mask_reg <= present_next;
        end
    end

    assign read_id      = res_reg.id;
    assign read_meta    = res_reg.meta;
    assign read_light   = res_reg.light;
    assign section_mask = mask_reg;

endmodule

`default_nettype wire

[tb/sectioned_voxel_store_tb.sv]
`timescale 1ns / 1ps

module sectioned_voxel_store_tb;
    import svs_pkg::*;

    // Request codes the block takes in but never acts on
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1527;
    localparam int IDLE_PERCENT = 21;
    localparam int CALM_FROM    = 700;    // no idling on either side from here ...
    localparam int CALM_TO      = 900;    // ... up to here
    localparam int DRAIN_AT     = 1100;   // sender pauses here until all results are in
    localparam int HOLD_AT      = 400;    // receiver holds off once this many are taken
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 16;
    // The clearing pass alone writes all STORE_DEPTH words with no transfer at all
    localparam int STALL_LIMIT  = 300000;
    localparam int HOT_SLOTS    = 24;

    // What one request should hand back
    typedef struct packed {
        logic [7:0]  id;
        logic [3:0]  meta;
        logic [3:0]  light;
        logic [15:0] mask;
    } voxel_reading_t;

    typedef struct packed {
        req_t           item;
        logic           typed;
        voxel_reading_t want;
    } stim_row_t;

    // Directed rows. Rows with typed set carry a result worked out by hand;
    // the rest are left to the predictor. Mask bits: section 0 on the first row,
    // section 15 from the second, section 7 on the get at height 0x70.
    localparam stim_row_t DIRECTED [23] = '{
        // fresh store right after reset
        '{'{REQ_GET_BLOCK, 4'd0,  8'h00, 4'd0,  8'h00, 4'd0,  4'd0},  1'b1,
          '{8'h00, 4'h0, 4'h0, 16'h0001}},
        '{'{REQ_GET_SKY,   4'd15, 8'hFF, 4'd15, 8'h00, 4'd0,  4'd0},  1'b1,
          '{8'h00, 4'h0, 4'hF, 16'h8001}},
        '{'{REQ_GET_BLK,   4'd15, 8'hFF, 4'd15, 8'h00, 4'd0,  4'd0},  1'b1,
          '{8'h00, 4'h0, 4'h0, 16'h8001}},
        // id and metadata at their top values, read straight back
        '{'{REQ_SET_BLOCK, 4'd15, 8'hFF, 4'd15, 8'hFF, 4'd15, 4'd0},  1'b1,
          '{8'h00, 4'h0, 4'h0, 16'h8001}},
        '{'{REQ_GET_BLOCK, 4'd15, 8'hFF, 4'd15, 8'h00, 4'd0,  4'd0},  1'b1,
          '{8'hFF, 4'hF, 4'h0, 16'h8001}},
        '{'{REQ_SET_SKY,   4'd0,  8'h00, 4'd0,  8'h00, 4'd0,  4'd0},  1'b1,
          '{8'h00, 4'h0, 4'h0, 16'h8001}},
        '{'{REQ_GET_SKY,   4'd0,  8'h00, 4'd0,  8'h00, 4'd0,  4'd0},  1'b1,
          '{8'h00, 4'h0, 4'h0, 16'h8001}},
        // full block light reads back unsigned
        '{'{REQ_SET_BLK,   4'd0,  8'h00, 4'd0,  8'h00, 4'd0,  4'd15}, 1'b1,
          '{8'h00, 4'h0, 4'h0, 16'h8001}},
        '{'{REQ_GET_BLK,   4'd0,  8'h00, 4'd0,  8'h00, 4'd0,  4'd0},  1'b1,
          '{8'h00, 4'h0, 4'hF, 16'h8001}},
        // a smaller level must replace the old one, not merge into it
        '{'{REQ_SET_BLK,   4'd0,  8'h00, 4'd0,  8'h00, 4'd0,  4'd3},  1'b1,
          '{8'h00, 4'h0, 4'h0, 16'h8001}},
        '{'{REQ_GET_BLK,   4'd0,  8'h00, 4'd0,  8'h00, 4'd0,  4'd0},  1'b1,
          '{8'h00, 4'h0, 4'h3, 16'h8001}},
        // unused codes: nothing stored, no section marked
        '{'{REQ_UNUSED_6,  4'd1,  8'h70, 4'd2,  8'hAA, 4'd5,  4'd9},  1'b1,
          '{8'h00, 4'h0, 4'h0, 16'h8001}},
        '{'{REQ_UNUSED_7,  4'd15, 8'h80, 4'd15, 8'hFF, 4'd15, 4'd15}, 1'b1,
          '{8'h00, 4'h0, 4'h0, 16'h8001}},
        '{'{REQ_GET_BLOCK, 4'd3,  8'h70, 4'd4,  8'h00, 4'd0,  4'd0},  1'b1,
          '{8'h00, 4'h0, 4'h0, 16'h8081}},
        // write fields on a read and light on a block write are ignored
        '{'{REQ_SET_BLOCK, 4'd5,  8'h37, 4'd9,  8'h5A, 4'd10, 4'd6},  1'b0, '0},
        '{'{REQ_GET_BLOCK, 4'd5,  8'h37, 4'd9,  8'hFF, 4'd15, 4'd15}, 1'b0, '0},
        '{'{REQ_SET_SKY,   4'd15, 8'hFF, 4'd15, 8'h12, 4'd4,  4'd7},  1'b0, '0},
        '{'{REQ_GET_SKY,   4'd15, 8'hFF, 4'd15, 8'h00, 4'd0,  4'd0},  1'b0, '0},
        '{'{REQ_SET_BLOCK, 4'd0,  8'h00, 4'd0,  8'h00, 4'd0,  4'd0},  1'b0, '0},
        '{'{REQ_GET_BLOCK, 4'd15, 8'hFF, 4'd15, 8'h00, 4'd0,  4'd0},  1'b0, '0},
        '{'{REQ_SET_SKY,   4'd0,  8'h00, 4'd0,  8'h00, 4'd0,  4'd15}, 1'b0, '0},
        '{'{REQ_GET_SKY,   4'd0,  8'h00, 4'd0,  8'h00, 4'd0,  4'd0},  1'b0, '0},
        // section 8 only now becomes present
        '{'{REQ_GET_BLOCK, 4'd8,  8'h8F, 4'd0,  8'h00, 4'd0,  4'd0},  1'b0, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  req_type;
    logic [3:0]  pos_x;
    logic [7:0]  pos_y;
    logic [3:0]  pos_z;
    logic [7:0]  block_id;
    logic [3:0]  block_meta;
    logic [3:0]  light_level;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_id;
    logic [3:0]  read_meta;
    logic [3:0]  read_light;
    logic [15:0] section_mask;

    // Shadow copy of the voxel column
    logic [7:0]  id_shadow [STORE_DEPTH];
    logic [3:0]  meta_shadow [STORE_DEPTH];
    logic [3:0]  blk_shadow [STORE_DEPTH];
    logic [3:0]  sky_shadow [STORE_DEPTH];
    logic [15:0] present_shadow;

    voxel_reading_t pending_readings[$];
    int             requests_taken;
    int             readings_checked;
    int             mismatch_count;

    // Directed rows hand their typed result to the sampler through these
    logic           typed_now;
    voxel_reading_t typed_reading;
    logic           calm;

    // Addresses revisited often, so that reads land on written voxels
    logic [15:0]    hot_addr [HOT_SLOTS];

    sectioned_voxel_store i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one request to the shadow column and return what it reads
    function automatic voxel_reading_t apply_voxel_request(input req_t r);
        voxel_reading_t res;
        logic [15:0]    addr;
        res  = '0;
        addr = {r.pos_y, r.pos_z, r.pos_x};
        if (r.req_type <= REQ_GET_SKY && int'(r.pos_y[7:4]) < NUM_SECTIONS)
        begin
            present_shadow[r.pos_y[7:4]] = 1'b1;
            case (r.req_type)
                REQ_SET_BLOCK:
                begin
                    id_shadow[addr]   = r.block_id;
                    meta_shadow[addr] = r.block_meta;
                end
                REQ_GET_BLOCK:
                begin
                    res.id   = id_shadow[addr];
                    res.meta = meta_shadow[addr];
                end
                REQ_SET_BLK: blk_shadow[addr] = r.light_level;
                REQ_GET_BLK: res.light = blk_shadow[addr];
                REQ_SET_SKY: sky_shadow[addr] = r.light_level;
                default:     res.light = sky_shadow[addr];
            endcase
        end
        res.mask = present_shadow;
        return res;
    endfunction

    function automatic logic roll_idle();
        return !calm && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // Mostly valid requests on a small set of hot voxels, some scattered, a few unused codes
    function automatic req_t random_request();
        req_t        r;
        logic [15:0] addr;
        int          slot;
        slot = $urandom_range(HOT_SLOTS - 1);
        if ($urandom_range(99) < 65)
            addr = hot_addr[slot];
        else
        begin
            addr = 16'($urandom);
            if ($urandom_range(3) == 0)
                hot_addr[slot] = addr;
        end
        r.req_type    = ($urandom_range(99) < 4) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(5));
        r.pos_y       = addr[15:8];
        r.pos_z       = addr[7:4];
        r.pos_x       = addr[3:0];
        r.block_id    = 8'($urandom);
        r.block_meta  = 4'($urandom);
        r.light_level = 4'($urandom);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
                 readings_checked, what, got, want);
        mismatch_count++;
    endtask

    // Offer one request at the falling edge, with random gaps ahead of it, and hold it
    // until the sampler has counted its transfer. Valid stays high into the next item.
    task automatic offer_request(input req_t r);
        int prev;
        while (roll_idle())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= r.req_type;
        pos_x       <= r.pos_x;
        pos_y       <= r.pos_y;
        pos_z       <= r.pos_z;
        block_id    <= r.block_id;
        block_meta  <= r.block_meta;
        light_level <= r.light_level;
        prev = requests_taken;
        do
            @(negedge clk);
        while (requests_taken == prev);
    endtask

    // Sample both channels at the rising edge. Drain the result side first: a result
    // can never belong to a request taken in the same cycle.
    always @(posedge clk)
    begin : sampler
        req_t           seen;
        voxel_reading_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_readings.size() == 0)
                    report_mismatch("result with nothing pending", int'(read_id), 0);
                else
                begin
                    want = pending_readings.pop_front();
                    if (read_id !== want.id)
                        report_mismatch("read_id", int'(read_id), int'(want.id));
                    if (read_meta !== want.meta)
                        report_mismatch("read_meta", int'(read_meta), int'(want.meta));
                    if (read_light !== want.light)
                        report_mismatch("read_light", int'(read_light), int'(want.light));
                    if (section_mask !== want.mask)
                        report_mismatch("section_mask", int'(section_mask),
                                        int'(want.mask));
                end
                readings_checked++;
            end
            if (in_valid && in_ready)
            begin
                seen.req_type    = req_type;
                seen.pos_x       = pos_x;
                seen.pos_y       = pos_y;
                seen.pos_z       = pos_z;
                seen.block_id    = block_id;
                seen.block_meta  = block_meta;
                seen.light_level = light_level;
                // keep the shadow in step even where the row gives the result
                want = apply_voxel_request(seen);
                if (typed_now)
                    want = typed_reading;
                pending_readings = {pending_readings, want};
                requests_taken++;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off so the block fills and
    // stalls its input while the sender keeps offering
    initial
    begin : receiver
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && !hold_done && requests_taken >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !roll_idle();
        end
    end

    // Watchdog: end the run once nothing has moved for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        req_type         = REQ_GET_BLOCK;
        pos_x            = '0;
        pos_y            = '0;
        pos_z            = '0;
        block_id         = '0;
        block_meta       = '0;
        light_level      = '0;
        typed_now        = 1'b0;
        typed_reading    = '0;
        calm             = 1'b0;
        requests_taken   = 0;
        readings_checked = 0;
        mismatch_count   = 0;
        present_shadow   = '0;
        for (n = 0; n < STORE_DEPTH; n++)
        begin
            id_shadow[n]   = '0;
            meta_shadow[n] = '0;
            blk_shadow[n]  = '0;
            sky_shadow[n]  = SKY_RESET;
        end
        for (n = 0; n < HOT_SLOTS; n++)
            hot_addr[n] = 16'($urandom);

        // Hold reset, release it at a falling edge; the clearing pass then keeps
        // in_ready low and the first offer simply waits it out
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            typed_now     = DIRECTED[i].typed;
            typed_reading = DIRECTED[i].want;
            offer_request(DIRECTED[i].item);
        end
        typed_now = 1'b0;

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= CALM_FROM && n < CALM_TO);
            if (n == DRAIN_AT)
            begin
                // pause the sender until every result is in
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (pending_readings.size() != 0);
            end
            offer_request(random_request());
        end
        in_valid <= 1'b0;

        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
rtl/core/svs_pkg.sv
rtl/core/svs_ram.sv
rtl/core/svs_seq.sv
rtl/core/svs_rmw.sv
rtl/core/sectioned_voxel_store.sv
tb/sectioned_voxel_store_tb.sv
